### sv/tql_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tql_pkg
// Shared types and constants for the tabular q-learning update block.
// ----------------------------------------------------------------------------
package tql_pkg;

    localparam int GAIN_W = 17;
    localparam int LIMIT_W = 5;
    localparam int DRAW_W = 16;

    typedef enum logic [1:0] {
        MODE_CHOOSE = 2'd0,
        MODE_UPDATE = 2'd1,
        MODE_READ   = 2'd2,
        MODE_READ_X = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_ALPHA = 2'd0,
        REG_GAMMA = 2'd1,
        REG_EPS   = 2'd2,
        REG_LIMIT = 2'd3
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_TARGET,
        ST_SAT1,
        ST_ALPHA,
        ST_WRITE,
        ST_OUT
    } t_state;

endpackage

### sv/tql_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tql_front
// Accepts input beats and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module tql_front #(
    parameter int ITEM_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [ITEM_W-1:0] i_item,
    output logic              o_valid,
    input  logic              i_take,
    output logic [ITEM_W-1:0] o_item
);
    import tql_pkg::*;

    logic [ITEM_W-1:0] r_slot [2];
    logic              r_wp, r_rp;
    logic [1:0]        r_cnt;
    logic              w_push, w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign w_push  = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop   = o_valid && i_take;
    assign o_item  = r_slot[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= i_item;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !w_push) else $error("push into full queue");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (r_cnt != 2'd0)) else $error("pop from empty queue");

endmodule

### sv/tql_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tql_back
// Sequencer for one queued item: table reads, for updates a fixed-point
// update with rounding and saturation plus write back, result register.
// After reset the known flags are swept to zero, one entry per cycle
// (DEPTH entries, 1024 by default); no item starts until the sweep ends.
// ----------------------------------------------------------------------------
module tql_back #(
    parameter int SUM_BITS  = 5,
    parameter int CARD_BITS = 4,
    parameter int Q_WIDTH   = 24,
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_take,
    input  tql_pkg::t_mode             i_mode,
    input  logic [SUM_BITS-1:0]        i_sum,
    input  logic [CARD_BITS-1:0]       i_card,
    input  logic                       i_soft,
    input  logic                       i_act,
    input  logic signed [Q_WIDTH-1:0]  i_reward,
    input  logic [SUM_BITS-1:0]        i_nsum,
    input  logic [CARD_BITS-1:0]       i_ncard,
    input  logic                       i_nsoft,
    input  logic                       i_term,
    input  logic [tql_pkg::DRAW_W-1:0] i_draw,
    input  logic                       i_coin,
    input  logic [tql_pkg::GAIN_W-1:0] i_alpha,
    input  logic [tql_pkg::GAIN_W-1:0] i_gamma,
    input  logic [tql_pkg::GAIN_W-1:0] i_eps,
    input  logic [tql_pkg::LIMIT_W-1:0] i_limit,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_chosen_action,
    output logic                       o_explored,
    output logic signed [Q_WIDTH-1:0]  o_q_value,
    output logic                       o_entry_known
);
    import tql_pkg::*;

    localparam int IDX_W = SUM_BITS + CARD_BITS + 1;
    localparam int DEPTH = 1 << IDX_W;
    localparam int P_W   = Q_WIDTH + GAIN_W + 2;
    localparam int D_W   = Q_WIDTH + 1;

    // tables: dual read, single write
    logic signed [Q_WIDTH-1:0] r_hit_mem [DEPTH];
    logic signed [Q_WIDTH-1:0] r_std_mem [DEPTH];
    logic                      r_known [DEPTH];

    t_state r_state, n_state;
    logic [IDX_W-1:0] w_cur, w_nxt;
    logic signed [Q_WIDTH-1:0] r_ch, r_cs, r_nh, r_ns;
    logic r_ck, r_nk;
    logic signed [Q_WIDTH-1:0] r_curq, r_target;
    logic signed [P_W-1:0] r_prod;
    logic signed [D_W-1:0] r_acc;
    logic r_out_v;
    logic r_o_act, r_o_exp, r_o_known;
    logic signed [Q_WIDTH-1:0] r_o_q;
    logic w_rd, w_wr, w_load;
    logic [IDX_W-1:0] r_clr_idx;
    logic r_clearing;
    logic signed [Q_WIDTH-1:0] w_maxn;
    logic signed [D_W-1:0] w_target_sat, w_newq;

    assign w_cur = {i_soft, i_card, i_sum};
    assign w_nxt = {i_nsoft, i_ncard, i_nsum};

    // known flag sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx  <= '0;
            r_clearing <= 1'b1;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == IDX_W'(DEPTH - 1)) r_clearing <= 1'b0;
        end
    end

    // known flags
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_known[r_clr_idx] <= 1'b0;
        end else if (w_wr) begin
            r_known[w_cur] <= 1'b1;
        end
    end

    function automatic logic signed [D_W-1:0] f_sat(input logic signed [D_W:0] v);
        logic signed [D_W:0] hi, lo;
        hi = (D_W+1)'((64'sd1 <<< (Q_WIDTH-1)) - 1);
        lo = -hi - 1;
        if (v > hi) return D_W'(hi);
        if (v < lo) return D_W'(lo);
        return D_W'(v);
    endfunction

    // rounded scale of a product, arithmetic shift gives the floor
    function automatic logic signed [D_W:0] f_round(input logic signed [P_W-1:0] p);
        logic signed [P_W-1:0] t;
        t = (p + (P_W'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS;
        return t[D_W:0];
    endfunction

    // best next value, saturated target and new value
    assign w_maxn       = (!i_term && r_nk) ? ((r_nh > r_ns) ? r_nh : r_ns) : '0;
    assign w_target_sat = f_sat((D_W+1)'(i_reward) + f_round(r_prod));
    assign w_newq       = f_sat((D_W+1)'(r_curq) + f_round(r_prod));

    // value tables
    always_ff @(posedge i_clk) begin
        if (w_rd) begin
            r_ch <= r_hit_mem[w_cur];
            r_cs <= r_std_mem[w_cur];
            r_nh <= r_hit_mem[w_nxt];
            r_ns <= r_std_mem[w_nxt];
            r_ck <= r_known[w_cur];
            r_nk <= r_known[w_nxt];
        end
        if (w_wr) begin
            r_hit_mem[w_cur] <= i_act ? (r_ck ? r_ch : '0) : w_newq[Q_WIDTH-1:0];
            r_std_mem[w_cur] <= i_act ? w_newq[Q_WIDTH-1:0] : (r_ck ? r_cs : '0);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_valid && !r_out_v && !r_clearing) n_state = ST_READ;
            ST_READ:   n_state = (i_mode == MODE_UPDATE) ? ST_TARGET : ST_OUT;
            ST_TARGET: n_state = ST_SAT1;
            ST_SAT1:   n_state = ST_ALPHA;
            ST_ALPHA:  n_state = ST_WRITE;
            ST_WRITE:  n_state = ST_OUT;
            ST_OUT:    n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        w_rd   = (r_state == ST_READ);
        w_wr   = (r_state == ST_WRITE);
        w_load = (r_state == ST_OUT);
        o_take = w_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // datapath: at most one multiply per step
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_TARGET: begin
                r_curq <= r_ck ? (i_act ? r_cs : r_ch) : '0;
                r_prod <= $signed({1'b0, i_gamma}) * w_maxn;
            end
            ST_SAT1: begin
                r_target <= w_target_sat[Q_WIDTH-1:0];
            end
            ST_ALPHA: begin
                r_prod <= $signed({1'b0, i_alpha}) *
                          ((D_W)'(r_target) - (D_W)'(r_curq));
            end
            ST_WRITE: begin
                r_acc <= w_newq;
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_load) begin
            r_out_v <= 1'b1;
        end else if (!i_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_known <= r_ck;
            r_o_act   <= 1'b0;
            r_o_exp   <= 1'b0;
            r_o_q     <= '0;
            case (i_mode)
                MODE_CHOOSE: begin
                    if ({1'b0, i_draw} < i_eps) begin
                        r_o_exp <= 1'b1;
                        r_o_act <= i_coin;
                    end else if (!r_ck) begin
                        r_o_act <= !(i_sum < i_limit);
                    end else begin
                        r_o_act <= !(r_ch > r_cs);
                    end
                end
                MODE_UPDATE: r_o_q <= r_acc[Q_WIDTH-1:0];
                default: if (r_ck) r_o_q <= i_act ? r_cs : r_ch;
            endcase
        end
    end

    assign o_valid         = r_out_v;
    assign o_chosen_action = r_o_act;
    assign o_explored      = r_o_exp;
    assign o_q_value       = r_o_q;
    assign o_entry_known   = r_o_known;

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_out_v) |=> (r_state == ST_IDLE))
        else $error("started while result pending");
    a_write_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |=> r_known[$past(w_cur)]) else $error("known flag not set");
    a_load_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> !r_out_v) else $error("result overwritten");

endmodule

### sv/tabular_q_learning_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tabular_q_learning_update
// Two-action q table with epsilon-greedy choice, update and read.
// Choose/read items step through the read and output states; updates
// also step through target, saturate, alpha and write, with two chained
// multiplies. An item starts only once the last result beat has left.
// Reset clears the queue and registers, then the known flags are swept one
// entry per cycle (1024 entries at default sizes) before the first item runs.
// ----------------------------------------------------------------------------
module tabular_q_learning_update #(
    parameter int SUM_BITS  = 5,
    parameter int CARD_BITS = 4,
    parameter int Q_WIDTH   = 24,
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_mode,
    input  logic [SUM_BITS-1:0]        i_player_sum,
    input  logic [CARD_BITS-1:0]       i_dealer_card,
    input  logic                       i_soft_ace,
    input  logic                       i_act,
    input  logic signed [Q_WIDTH-1:0]  i_reward,
    input  logic [SUM_BITS-1:0]        i_next_player_sum,
    input  logic [CARD_BITS-1:0]       i_next_dealer_card,
    input  logic                       i_next_soft_ace,
    input  logic                       i_terminal,
    input  logic [tql_pkg::DRAW_W-1:0] i_explore_draw,
    input  logic                       i_coin,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_chosen_action,
    output logic                       o_explored,
    output logic signed [Q_WIDTH-1:0]  o_q_value,
    output logic                       o_entry_known,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [tql_pkg::GAIN_W-1:0] i_cfg_data
);
    import tql_pkg::*;

    localparam int ITEM_W = 2 + 2*SUM_BITS + 2*CARD_BITS + 5 + Q_WIDTH + DRAW_W;

    logic [GAIN_W-1:0] r_alpha, r_gamma, r_eps;
    logic [LIMIT_W-1:0] r_limit;
    logic [ITEM_W-1:0] w_qi;
    logic w_qv, w_take;

    logic [1:0] q_mode;
    logic [SUM_BITS-1:0] q_sum, q_nsum;
    logic [CARD_BITS-1:0] q_card, q_ncard;
    logic q_soft, q_act, q_nsoft, q_term, q_coin;
    logic signed [Q_WIDTH-1:0] q_rew;
    logic [DRAW_W-1:0] q_draw;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= GAIN_W'(6554);
            r_gamma <= GAIN_W'(58982);
            r_eps   <= GAIN_W'(6554);
            r_limit <= LIMIT_W'(17);
        end else if (i_cfg_valid) begin
            unique case (t_reg'(i_cfg_index))
                REG_ALPHA: r_alpha <= i_cfg_data;
                REG_GAMMA: r_gamma <= i_cfg_data;
                REG_EPS:   r_eps   <= i_cfg_data;
                REG_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    tql_front #(.ITEM_W(ITEM_W)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_item({i_mode, i_player_sum, i_dealer_card, i_soft_ace, i_act, i_reward,
                 i_next_player_sum, i_next_dealer_card, i_next_soft_ace,
                 i_terminal, i_explore_draw, i_coin}),
        .o_valid(w_qv), .i_take(w_take), .o_item(w_qi)
    );

    assign {q_mode, q_sum, q_card, q_soft, q_act, q_rew, q_nsum, q_ncard,
            q_nsoft, q_term, q_draw, q_coin} = w_qi;

    tql_back #(
        .SUM_BITS(SUM_BITS), .CARD_BITS(CARD_BITS),
        .Q_WIDTH(Q_WIDTH), .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_take(w_take),
        .i_mode(t_mode'(q_mode)), .i_sum(q_sum), .i_card(q_card), .i_soft(q_soft),
        .i_act(q_act), .i_reward(q_rew), .i_nsum(q_nsum), .i_ncard(q_ncard),
        .i_nsoft(q_nsoft), .i_term(q_term), .i_draw(q_draw), .i_coin(q_coin),
        .i_alpha(r_alpha), .i_gamma(r_gamma), .i_eps(r_eps), .i_limit(r_limit),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_chosen_action(o_chosen_action), .o_explored(o_explored),
        .o_q_value(o_q_value), .o_entry_known(o_entry_known)
    );

endmodule
